@@ rtl/assert_macros.svh @@
// Shared assertion helpers. Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define MLOL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define MLOL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/mlol_pkg.sv @@
package mlol_pkg;

  localparam int KIND_W  = 2;
  localparam int FACE_W  = 3;
  localparam int DIM_W   = 12;
  localparam int TB_W    = 3;
  localparam int LVL_W   = 4;
  localparam int OFF_W   = 28;
  localparam int PITCH_W = 15;
  localparam int SLICE_W = 28;
  localparam int TOTAL_W = 48;

  localparam int MAX_LEVELS        = 12;
  localparam int MIN_VOLUME_LEVELS = 9;
  localparam int DIM_MAX           = 2048;
  localparam int TB_MAX            = 4;
  localparam int FACES             = 6;

  localparam int LEN_W  = $clog2(DIM_W + 1);
  localparam int ROWS_W = 14;
  localparam int XY_W   = 14;
  localparam int OFFP_W = 30;
  localparam int PROD_W = 29;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLAIN  = 2'd0,
    KIND_CUBE   = 2'd1,
    KIND_VOLUME = 2'd2
  } kind_t;

  // Cube face layout: row position of level zero and row step per level, in
  // units of the current level size. Faces that start in the right column
  // move left by one level size per level.
  localparam logic [1:0] FACE_Y_BASE [FACES] = '{2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd3};
  localparam logic [1:0] FACE_Y_STEP [FACES] = '{2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1};
  localparam logic       FACE_X_MOVE [FACES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

  typedef struct packed {
    kind_t              kind;
    logic [FACE_W-1:0]  face;
    logic [DIM_W-1:0]   width;
    logic [TB_W-1:0]    texel_bytes;
    logic [DIM_W-1:0]   depth;
    logic [PITCH_W-1:0] pitch;
    logic [LVL_W-1:0]   level;
    logic               last;
  } lvl_ctl_t;

  function automatic logic [LEN_W-1:0] bit_len(input logic [DIM_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int k = 0; k < DIM_W; k++) begin
      if (v[k]) n = LEN_W'(k + 1);
    end
    return n;
  endfunction

  function automatic logic [LEN_W-1:0] pop_count(input logic [DIM_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int k = 0; k < DIM_W; k++) begin
      n = n + LEN_W'(v[k]);
    end
    return n;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(DIM_MAX)) begin
      r = DIM_W'(DIM_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/mlol_ifs.sv @@
interface mlol_desc_if;
  logic                         valid;
  logic                         ready;
  logic [mlol_pkg::KIND_W-1:0]  target_kind;
  logic [mlol_pkg::FACE_W-1:0]  face;
  logic [mlol_pkg::DIM_W-1:0]   base_width;
  logic [mlol_pkg::DIM_W-1:0]   base_height;
  logic [mlol_pkg::DIM_W-1:0]   base_depth;
  logic [mlol_pkg::TB_W-1:0]    texel_bytes;
  logic [mlol_pkg::LVL_W-1:0]   level_count;
  logic                         compressed;

  modport source (
    output valid, target_kind, face, base_width, base_height, base_depth,
           texel_bytes, level_count, compressed,
    input  ready
  );
  modport sink (
    input  valid, target_kind, face, base_width, base_height, base_depth,
           texel_bytes, level_count, compressed,
    output ready
  );
endinterface

interface mlol_level_if;
  logic                          valid;
  logic                          ready;
  logic [mlol_pkg::LVL_W-1:0]    level;
  logic [mlol_pkg::OFF_W-1:0]    level_offset;
  logic [mlol_pkg::PITCH_W-1:0]  pitch_bytes;
  logic [mlol_pkg::SLICE_W-1:0]  slice_size;
  logic [mlol_pkg::TOTAL_W-1:0]  total_size;
  logic                          last;

  modport source (
    output valid, level, level_offset, pitch_bytes, slice_size, total_size, last,
    input  ready
  );
  modport sink (
    input  valid, level, level_offset, pitch_bytes, slice_size, total_size, last,
    output ready
  );
endinterface

@@ rtl/mipmap_level_offset_layout_core.sv @@
// Flow: a request is registered in the level sequencer; its levels pass through stages s1 to s5.
// Throughput: one level result per cycle; a request occupies the level sequencer for
// its level_count levels (1 to 12), and the next request is taken in the cycle its last
// level enters the five-stage pipeline, which stalls as a whole on output backpressure.
// Reset: synchronous active-high rst clears the sequencer and all stage valid bits.
`include "assert_macros.svh"

module mipmap_level_offset_layout_core (
  input  logic         clk,
  input  logic         rst,
  mlol_desc_if.sink    desc,
  mlol_level_if.source levels
);

  logic adv;

  // Level sequencer holding the clamped request.
  logic                          busy;
  logic [mlol_pkg::LVL_W-1:0]    seq_i;
  mlol_pkg::kind_t               seq_kind;
  logic [mlol_pkg::FACE_W-1:0]   seq_face;
  logic [mlol_pkg::DIM_W-1:0]    seq_w;
  logic [mlol_pkg::DIM_W-1:0]    seq_h;
  logic [mlol_pkg::DIM_W-1:0]    seq_d;
  logic [mlol_pkg::TB_W-1:0]     seq_tb;
  logic [mlol_pkg::LVL_W-1:0]    seq_n;
  logic                          seq_comp;
  logic                          seq_last;

  mlol_pkg::kind_t               kind_in;
  logic [mlol_pkg::FACE_W-1:0]   face_in;
  logic [mlol_pkg::TB_W-1:0]     tb_in;
  logic [mlol_pkg::LVL_W-1:0]    n_in;
  logic                          accept;

  // Stage 1 signals.
  logic [mlol_pkg::PITCH_W-1:0]  wt;
  logic [mlol_pkg::PITCH_W:0]    praw;
  logic [mlol_pkg::PITCH_W:0]    psum;
  logic                          plain_comp;
  logic [mlol_pkg::DIM_W-1:0]    g;
  logic [mlol_pkg::LEN_W-1:0]    bl;
  logic [mlol_pkg::LEN_W-1:0]    lim;
  logic [mlol_pkg::LVL_W-1:0]    nres;
  logic [mlol_pkg::LVL_W-1:0]    m_off;
  logic [mlol_pkg::LVL_W-1:0]    m_tot;
  logic [mlol_pkg::LVL_W-1:0]    mc;

  logic                          v1;
  mlol_pkg::lvl_ctl_t            s1_ctl;
  logic [mlol_pkg::DIM_W-1:0]    s1_g;
  logic [mlol_pkg::DIM_W-1:0]    s1_gs_off;
  logic [mlol_pkg::DIM_W-1:0]    s1_gs_tot;
  logic                          s1_c_two;
  logic [mlol_pkg::LVL_W-1:0]    s1_i_off;
  logic [mlol_pkg::LVL_W-1:0]    s1_n_tot;
  logic [mlol_pkg::DIM_W-1:0]    s1_wsh;

  // Stage 2 signals.
  logic [mlol_pkg::ROWS_W:0]     f_off;
  logic [mlol_pkg::ROWS_W:0]     f_tot;
  logic [mlol_pkg::ROWS_W-1:0]   s_sum;

  logic                          v2;
  mlol_pkg::lvl_ctl_t            s2_ctl;
  logic [mlol_pkg::ROWS_W-1:0]   s2_f_off;
  logic [mlol_pkg::ROWS_W-1:0]   s2_f_tot;
  logic [mlol_pkg::DIM_W-1:0]    s2_s;

  // Stage 3 signals.
  logic                          v3;
  mlol_pkg::lvl_ctl_t            s3_ctl;
  logic [mlol_pkg::ROWS_W-1:0]   s3_f_off;
  logic [mlol_pkg::ROWS_W-1:0]   s3_f_tot;
  logic [mlol_pkg::DIM_W-1:0]    s3_x;
  logic [mlol_pkg::XY_W-1:0]     s3_y;

  // Stage 4 signals.
  logic                          v4;
  mlol_pkg::lvl_ctl_t            s4_ctl;
  logic [mlol_pkg::OFFP_W-1:0]   s4_off;
  logic [mlol_pkg::PROD_W-1:0]   s4_prod;

  // Output stage.
  logic                          v5;
  mlol_pkg::kind_t               s5_kind;
  logic [mlol_pkg::LVL_W-1:0]    s5_level;
  logic [mlol_pkg::OFF_W-1:0]    s5_off;
  logic [mlol_pkg::PITCH_W-1:0]  s5_pitch;
  logic [mlol_pkg::SLICE_W-1:0]  s5_slice;
  logic [mlol_pkg::TOTAL_W-1:0]  s5_total;
  logic                          s5_last;

  assign adv      = !v5 || levels.ready;
  assign seq_last = (seq_i == seq_n - mlol_pkg::LVL_W'(1));
  assign desc.ready = !busy || (adv && seq_last);
  assign accept   = desc.valid && desc.ready;

  always_comb begin
    unique case (desc.target_kind)
      mlol_pkg::KIND_CUBE:   kind_in = mlol_pkg::KIND_CUBE;
      mlol_pkg::KIND_VOLUME: kind_in = mlol_pkg::KIND_VOLUME;
      default:               kind_in = mlol_pkg::KIND_PLAIN;
    endcase
    face_in = (desc.face > mlol_pkg::FACE_W'(mlol_pkg::FACES - 1)) ? '0 : desc.face;
    if (desc.texel_bytes == '0) begin
      tb_in = mlol_pkg::TB_W'(1);
    end else if (desc.texel_bytes > mlol_pkg::TB_W'(mlol_pkg::TB_MAX)) begin
      tb_in = mlol_pkg::TB_W'(mlol_pkg::TB_MAX);
    end else begin
      tb_in = desc.texel_bytes;
    end
    if (desc.level_count == '0) begin
      n_in = mlol_pkg::LVL_W'(1);
    end else if (desc.level_count > mlol_pkg::LVL_W'(mlol_pkg::MAX_LEVELS)) begin
      n_in = mlol_pkg::LVL_W'(mlol_pkg::MAX_LEVELS);
    end else begin
      n_in = desc.level_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      seq_i <= '0;
    end else if (accept) begin
      busy  <= 1'b1;
      seq_i <= '0;
    end else if (busy && adv) begin
      busy  <= !seq_last;
      seq_i <= seq_i + mlol_pkg::LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seq_kind <= kind_in;
      seq_face <= face_in;
      seq_w    <= mlol_pkg::clamp_dim(desc.base_width);
      seq_h    <= mlol_pkg::clamp_dim(desc.base_height);
      seq_d    <= mlol_pkg::clamp_dim(desc.base_depth);
      seq_tb   <= tb_in;
      seq_n    <= n_in;
      seq_comp <= desc.compressed;
    end
  end

  // Row sums use sum(g >> k, k < m) = 2g - 2(g >> m) - pop(g) + pop(g >> m);
  // levels past the point where g >> k drops below the row minimum add the minimum.
  always_comb begin
    wt   = mlol_pkg::PITCH_W'(seq_w) * mlol_pkg::PITCH_W'(seq_tb);
    praw = (seq_kind == mlol_pkg::KIND_CUBE) ? {wt, 1'b0} : {1'b0, wt};
    psum = praw + (mlol_pkg::PITCH_W + 1)'(3);
    plain_comp = (seq_kind == mlol_pkg::KIND_PLAIN) && seq_comp;
    g    = plain_comp ? (seq_h >> 2) : seq_h;
    bl   = mlol_pkg::bit_len(g);
    if (plain_comp) begin
      lim = bl;
    end else begin
      lim = (bl == '0) ? '0 : bl - mlol_pkg::LEN_W'(1);
    end
    if ((seq_kind == mlol_pkg::KIND_VOLUME) &&
        (seq_n < mlol_pkg::LVL_W'(mlol_pkg::MIN_VOLUME_LEVELS))) begin
      nres = mlol_pkg::LVL_W'(mlol_pkg::MIN_VOLUME_LEVELS);
    end else begin
      nres = seq_n;
    end
    m_off = (mlol_pkg::LEN_W'(seq_i) < lim) ? seq_i : mlol_pkg::LVL_W'(lim);
    m_tot = (mlol_pkg::LEN_W'(nres) < lim) ? nres : mlol_pkg::LVL_W'(lim);
    mc    = seq_i + mlol_pkg::LVL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl.kind        <= seq_kind;
      s1_ctl.face        <= seq_face;
      s1_ctl.width       <= seq_w;
      s1_ctl.texel_bytes <= seq_tb;
      s1_ctl.depth       <= seq_d;
      s1_ctl.pitch       <= {psum[mlol_pkg::PITCH_W-1:2], 2'b00};
      s1_ctl.level       <= seq_i;
      s1_ctl.last        <= seq_last;
      s1_g      <= g;
      s1_gs_off <= g >> m_off;
      s1_gs_tot <= g >> m_tot;
      s1_c_two  <= !plain_comp;
      s1_i_off  <= seq_i - m_off;
      s1_n_tot  <= nres - m_tot;
      s1_wsh    <= seq_w >> mc;
    end
  end

  always_comb begin
    f_off = (mlol_pkg::ROWS_W + 1)'({s1_g, 1'b0})
          + (mlol_pkg::ROWS_W + 1)'(mlol_pkg::pop_count(s1_gs_off))
          + (mlol_pkg::ROWS_W + 1)'(s1_c_two ? {s1_i_off, 1'b0} : {1'b0, s1_i_off})
          - (mlol_pkg::ROWS_W + 1)'({s1_gs_off, 1'b0})
          - (mlol_pkg::ROWS_W + 1)'(mlol_pkg::pop_count(s1_g));
    f_tot = (mlol_pkg::ROWS_W + 1)'({s1_g, 1'b0})
          + (mlol_pkg::ROWS_W + 1)'(mlol_pkg::pop_count(s1_gs_tot))
          + (mlol_pkg::ROWS_W + 1)'(s1_c_two ? {s1_n_tot, 1'b0} : {1'b0, s1_n_tot})
          - (mlol_pkg::ROWS_W + 1)'({s1_gs_tot, 1'b0})
          - (mlol_pkg::ROWS_W + 1)'(mlol_pkg::pop_count(s1_g));
    s_sum = mlol_pkg::ROWS_W'(s1_ctl.width)
          + mlol_pkg::ROWS_W'(mlol_pkg::pop_count(s1_wsh))
          - mlol_pkg::ROWS_W'({s1_wsh, 1'b0})
          - mlol_pkg::ROWS_W'(mlol_pkg::pop_count(s1_ctl.width));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl   <= s1_ctl;
      s2_f_off <= f_off[mlol_pkg::ROWS_W-1:0];
      s2_f_tot <= f_tot[mlol_pkg::ROWS_W-1:0];
      s2_s     <= s_sum[mlol_pkg::DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ctl   <= s2_ctl;
      s3_f_off <= s2_f_off;
      s3_f_tot <= s2_f_tot;
      s3_x     <= mlol_pkg::FACE_X_MOVE[s2_ctl.face] ? (s2_ctl.width - s2_s) : '0;
      s3_y     <= mlol_pkg::XY_W'(mlol_pkg::FACE_Y_BASE[s2_ctl.face])
                * mlol_pkg::XY_W'(s2_ctl.width)
                + mlol_pkg::XY_W'(mlol_pkg::FACE_Y_STEP[s2_ctl.face])
                * mlol_pkg::XY_W'(s2_s);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ctl <= s3_ctl;
      if (s3_ctl.kind == mlol_pkg::KIND_CUBE) begin
        s4_off  <= mlol_pkg::OFFP_W'(s3_y) * mlol_pkg::OFFP_W'(s3_ctl.pitch)
                 + mlol_pkg::OFFP_W'(s3_x) * mlol_pkg::OFFP_W'(s3_ctl.texel_bytes);
        s4_prod <= mlol_pkg::PROD_W'(s3_ctl.width) * mlol_pkg::PROD_W'(s3_ctl.pitch);
      end else begin
        s4_off  <= mlol_pkg::OFFP_W'(s3_f_off) * mlol_pkg::OFFP_W'(s3_ctl.pitch);
        s4_prod <= mlol_pkg::PROD_W'(s3_f_tot) * mlol_pkg::PROD_W'(s3_ctl.pitch);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_kind  <= s4_ctl.kind;
      s5_level <= s4_ctl.level;
      s5_off   <= s4_off[mlol_pkg::OFF_W-1:0];
      s5_pitch <= s4_ctl.pitch;
      s5_last  <= s4_ctl.last;
      if (s4_ctl.kind == mlol_pkg::KIND_VOLUME) begin
        s5_slice <= s4_prod[mlol_pkg::SLICE_W-1:0];
        s5_total <= mlol_pkg::TOTAL_W'(s4_prod) * mlol_pkg::TOTAL_W'(s4_ctl.depth);
      end else if (s4_ctl.kind == mlol_pkg::KIND_CUBE) begin
        s5_slice <= '0;
        s5_total <= mlol_pkg::TOTAL_W'({s4_prod, 2'b00});
      end else begin
        s5_slice <= '0;
        s5_total <= mlol_pkg::TOTAL_W'(s4_prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  assign levels.valid        = v5;
  assign levels.level        = s5_level;
  assign levels.level_offset = s5_off;
  assign levels.pitch_bytes  = s5_pitch;
  assign levels.slice_size   = s5_slice;
  assign levels.total_size   = s5_total;
  assign levels.last         = s5_last;

  `MLOL_ASSERT_IMPL(a_level_follows, v5 && !s5_last, v4 && (s4_ctl.level == s5_level + 1'b1), "level sequence broken in pipeline")
  `MLOL_ASSERT_IMPL(a_seq_in_range, busy, seq_i < seq_n, "sequencer level past level count")
  `MLOL_ASSERT(a_pitch_aligned, !levels.valid || (levels.pitch_bytes[1:0] == 2'b00), "pitch not a multiple of four")
  `MLOL_ASSERT_IMPL(a_slice_zero, v5 && (s5_kind != mlol_pkg::KIND_VOLUME), levels.slice_size == '0, "slice size set on non-volume kind")

endmodule

@@ test/mip_layout_checker.sv @@
module mip_layout_checker (
  input  logic  clk,
  input  logic  rst,
  mlol_desc_if  desc,
  mlol_level_if levels,
  output int    fails,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import mlol_pkg::*;

  typedef struct packed {
    logic [LVL_W-1:0]   level;
    logic [OFF_W-1:0]   offset;
    logic [PITCH_W-1:0] pitch;
    logic [SLICE_W-1:0] slice;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } level_rec_t;

  // Cube faces sit in two columns; each face's chain starts at a fixed cell and
  // moves by a fixed step, both in units of the current level size.
  localparam longint FACE_X0 [FACES] = '{0, 0, 1, 1, 1, 1};
  localparam longint FACE_Y0 [FACES] = '{0, 2, 0, 2, 1, 3};
  localparam longint FACE_DX [FACES] = '{0, 0, -1, -1, -1, -1};
  localparam longint FACE_DY [FACES] = '{2, 2, 2, 2, 1, 1};

  level_rec_t planned_levels [$];
  level_rec_t want;
  int fail_count = 0;

  function automatic logic [63:0] fit(input logic [63:0] v, input logic [63:0] lo,
                                      input logic [63:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void plan_levels(input logic [KIND_W-1:0] kind,
                                      input logic [FACE_W-1:0] face_in,
                                      input logic [DIM_W-1:0] bw, input logic [DIM_W-1:0] bh,
                                      input logic [DIM_W-1:0] bd,
                                      input logic [TB_W-1:0] tb_in,
                                      input logic [LVL_W-1:0] cnt, input logic comp);
    logic [63:0] w, h, dep, tb, pitch, slice, total, rows, vh, lh;
    logic [63:0] offs [MAX_LEVELS];
    longint d, x, y;
    int n, reserved, f, i;
    level_rec_t rec;
    w = fit(64'(bw), 1, DIM_MAX);
    h = fit(64'(bh), 1, DIM_MAX);
    dep = fit(64'(bd), 1, DIM_MAX);
    tb = fit(64'(tb_in), 1, TB_MAX);
    n = int'(fit(64'(cnt), 1, MAX_LEVELS));
    rows = 0;
    slice = 0;
    if (kind == KIND_CUBE) begin
      f = (face_in >= FACES) ? 0 : int'(face_in);
      pitch = (w * tb * 2 + 3) & ~64'd3;
      d = longint'(w);
      x = FACE_X0[f] * d;
      y = FACE_Y0[f] * d;
      for (i = 0; i < n; i++) begin
        offs[i] = 64'(y * longint'(pitch) + x * longint'(tb));
        d = d >>> 1;
        x += FACE_DX[f] * d;
        y += FACE_DY[f] * d;
      end
      total = w * 4 * pitch;
    end else if (kind == KIND_VOLUME) begin
      reserved = (n < MIN_VOLUME_LEVELS) ? MIN_VOLUME_LEVELS : n;
      vh = h;
      pitch = (w * tb + 3) & ~64'd3;
      for (i = 0; i < reserved; i++) begin
        if (i < n) offs[i] = rows * pitch;
        rows += (vh > 2) ? vh : 64'd2;
        vh = vh >> 1;
      end
      slice = rows * pitch;
      total = slice * dep;
    end else begin
      pitch = (w * tb + 3) & ~64'd3;
      for (i = 0; i < n; i++) begin
        offs[i] = rows * pitch;
        lh = h >> i;
        if (lh == 0) lh = 1;
        if (comp) begin
          rows += (lh > 4) ? lh / 4 : 64'd1;
        end else begin
          rows += (lh > 2) ? lh : 64'd2;
        end
      end
      total = rows * pitch;
    end
    for (i = 0; i < n; i++) begin
      rec.level = LVL_W'(i);
      rec.offset = offs[i][OFF_W-1:0];
      rec.pitch = pitch[PITCH_W-1:0];
      rec.slice = slice[SLICE_W-1:0];
      rec.total = total[TOTAL_W-1:0];
      rec.last = (i == n - 1);
      planned_levels.push_back(rec);
    end
  endfunction

  function automatic void match_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (desc.valid && desc.ready) begin
        plan_levels(desc.target_kind, desc.face, desc.base_width, desc.base_height,
                    desc.base_depth, desc.texel_bytes, desc.level_count, desc.compressed);
      end
      if (levels.valid && levels.ready) begin
        if (planned_levels.size() == 0) begin
          $error("level result %0d arrived with no request outstanding", levels.level);
          fail_count++;
        end else begin
          want = planned_levels.pop_front();
          match_field("level", 64'(want.level), 64'(levels.level));
          match_field("level_offset", 64'(want.offset), 64'(levels.level_offset));
          match_field("pitch_bytes", 64'(want.pitch), 64'(levels.pitch_bytes));
          match_field("slice_size", 64'(want.slice), 64'(levels.slice_size));
          match_field("total_size", 64'(want.total), 64'(levels.total_size));
          match_field("last", 64'(want.last), 64'(levels.last));
        end
      end
    end
    fails <= fail_count;
    pending <= planned_levels.size();
  end

endmodule

@@ test/mipmap_level_offset_layout_core_test.sv @@
module mipmap_level_offset_layout_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mlol_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 360;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [FACE_W-1:0] face;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  d;
    logic [TB_W-1:0]   tb;
    logic [LVL_W-1:0]  cnt;
    logic              comp;
  } tex_desc_t;

  logic clk = 1'b0;
  logic rst;
  int fails;
  int pending;
  int src_mode = 0;
  int sink_mode = 0;
  int stall_left = 0;
  int quiet = 0;

  mlol_desc_if  desc_ch ();
  mlol_level_if level_ch ();

  mipmap_level_offset_layout_core uut (
    .clk    (clk),
    .rst    (rst),
    .desc   (desc_ch),
    .levels (level_ch)
  );

  mip_layout_checker layout_check (
    .clk     (clk),
    .rst     (rst),
    .desc    (desc_ch),
    .levels  (level_ch),
    .fails   (fails),
    .pending (pending)
  );

  always #5ns clk = ~clk;

  function automatic tex_desc_t make_desc(input logic [KIND_W-1:0] kind,
                                          input logic [FACE_W-1:0] face,
                                          input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                          input logic [DIM_W-1:0] d, input logic [TB_W-1:0] tb,
                                          input logic [LVL_W-1:0] cnt, input logic comp);
    tex_desc_t t;
    t.kind = kind;
    t.face = face;
    t.w = w;
    t.h = h;
    t.d = d;
    t.tb = tb;
    t.cnt = cnt;
    t.comp = comp;
    return t;
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return DIM_W'($urandom_range(0, 4095));
    if (r < 3) return DIM_W'(1 << $urandom_range(0, 11));
    if (r == 3) return ($urandom_range(0, 1) != 0) ? DIM_W'(1) : DIM_W'(DIM_MAX);
    return DIM_W'($urandom_range(1, DIM_MAX));
  endfunction

  function automatic tex_desc_t random_desc();
    tex_desc_t t;
    int r;
    r = $urandom_range(0, 15);
    if (r < 5) begin
      t.kind = KIND_PLAIN;
    end else if (r < 10) begin
      t.kind = KIND_CUBE;
    end else if (r < 15) begin
      t.kind = KIND_VOLUME;
    end else begin
      t.kind = KIND_SPARE;
    end
    t.face = FACE_W'($urandom_range(0, 7));
    t.w = random_dim();
    t.h = random_dim();
    t.d = random_dim();
    t.tb = ($urandom_range(0, 5) != 0) ? TB_W'($urandom_range(1, TB_MAX))
                                       : TB_W'($urandom_range(0, 7));
    t.cnt = ($urandom_range(0, 5) != 0) ? LVL_W'($urandom_range(1, MAX_LEVELS))
                                        : LVL_W'($urandom_range(0, 15));
    t.comp = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic send_desc(input tex_desc_t t);
    int gap;
    gap = 0;
    if (src_mode == 1 && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
    if (src_mode == 2 && $urandom_range(0, 1) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      desc_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    desc_ch.valid <= 1'b1;
    desc_ch.target_kind <= t.kind;
    desc_ch.face <= t.face;
    desc_ch.base_width <= t.w;
    desc_ch.base_height <= t.h;
    desc_ch.base_depth <= t.d;
    desc_ch.texel_bytes <= t.tb;
    desc_ch.level_count <= t.cnt;
    desc_ch.compressed <= t.comp;
    do @(posedge clk); while (!desc_ch.ready);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (sink_mode != 0 && $urandom_range(0, (sink_mode == 1) ? 15 : 3) == 0) begin
      level_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      level_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (desc_ch.valid && desc_ch.ready) || (level_ch.valid && level_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst = 1'b1;
    desc_ch.valid = 1'b0;
    desc_ch.target_kind = '0;
    desc_ch.face = '0;
    desc_ch.base_width = '0;
    desc_ch.base_height = '0;
    desc_ch.base_depth = '0;
    desc_ch.texel_bytes = '0;
    desc_ch.level_count = '0;
    desc_ch.compressed = 1'b0;
    level_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_desc(make_desc(KIND_PLAIN, 0, 1, 1, 1, 1, 1, 0));
    send_desc(make_desc(KIND_PLAIN, 0, 2048, 2048, 1, 4, 12, 0));
    send_desc(make_desc(KIND_PLAIN, 3, 2048, 2048, 1, 4, 12, 1));
    send_desc(make_desc(KIND_PLAIN, 0, 7, 3, 1, 3, 4, 1));
    send_desc(make_desc(KIND_PLAIN, 0, 13, 5, 1, 3, 3, 1));
    send_desc(make_desc(KIND_PLAIN, 0, 0, 0, 0, 0, 0, 0));
    send_desc(make_desc(KIND_SPARE, 7, 4095, 4095, 4095, 7, 15, 1));
    send_desc(make_desc(KIND_PLAIN, 0, 2047, 2047, 1, 3, 12, 0));
    send_desc(make_desc(KIND_PLAIN, 0, 3, 3, 1, 1, 5, 0));
    for (int f = 0; f < FACES; f++) begin
      send_desc(make_desc(KIND_CUBE, FACE_W'(f), 2048, 2048, 1, 4, 12, 0));
    end
    send_desc(make_desc(KIND_CUBE, 6, 64, 1, 1, 2, 12, 1));
    send_desc(make_desc(KIND_CUBE, 7, 1, 9, 1, 1, 3, 0));
    send_desc(make_desc(KIND_CUBE, 5, 4095, 5, 1, 7, 15, 0));
    send_desc(make_desc(KIND_VOLUME, 0, 2048, 2048, 2048, 4, 12, 0));
    send_desc(make_desc(KIND_VOLUME, 0, 1, 1, 1, 1, 1, 0));
    send_desc(make_desc(KIND_VOLUME, 2, 100, 7, 0, 3, 9, 1));
    send_desc(make_desc(KIND_VOLUME, 0, 4095, 4095, 4095, 0, 0, 0));
    send_desc(make_desc(KIND_VOLUME, 7, 33, 2048, 5, 2, 10, 0));
    send_desc(make_desc(KIND_SPARE, 0, 1, 2048, 1, 1, 12, 0));

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 40 == 0) begin
        src_mode = (k >= RANDOM_ITEMS - 60) ? 0 : $urandom_range(0, 2);
        sink_mode = (k >= RANDOM_ITEMS - 60) ? 0 : $urandom_range(0, 2);
      end
      send_desc(random_desc());
    end
    desc_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mlol_pkg.sv
rtl/mlol_ifs.sv
rtl/mipmap_level_offset_layout_core.sv
test/mip_layout_checker.sv
test/mipmap_level_offset_layout_core_test.sv
